// ===== src/b64e_pkg.sv =====
package b64e_pkg;

   // one encoded character with its end-of-message flag
   typedef struct packed {
      logic [6:0] out_char;
      logic       final_char;
   } char_type;

   // what one byte produces: one or two characters
   typedef struct packed {
      logic     valid;
      logic     two;
      char_type first;
      char_type second;
   } push_type;

   // position of the next byte inside its group of three
   typedef enum logic [2:0] {
      PHASE_START = 3'b001,
      PHASE_ONE   = 3'b010,
      PHASE_TWO   = 3'b100
   } phase_type;

   // alphabet segments: dot, slash and digits, then upper, then lower case
   localparam logic [5:0] UPPER_FIRST   = 6'd12;
   localparam logic [5:0] LOWER_FIRST   = 6'd38;
   localparam logic [6:0] PUNCT_OFFSET  = 7'd46;
   localparam logic [6:0] UPPER_OFFSET  = 7'd53;
   localparam logic [6:0] LOWER_OFFSET  = 7'd59;

   // queue depth in characters
   localparam int unsigned QUEUE_DEPTH  = 2;

   // sextet value to ascii code of the crypt alphabet
   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] w;
      w = {1'b0, v};
      if (v < UPPER_FIRST) begin
         return w + PUNCT_OFFSET;
      end else if (v < LOWER_FIRST) begin
         return w + UPPER_OFFSET;
      end
      return w + LOWER_OFFSET;
   endfunction

endpackage

// ===== src/b64e_if.sv =====
// byte channel
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// character channel
interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       final_char;

   modport source (output valid, output out_char, output final_char, input ready);
   modport sink (input valid, input out_char, input final_char, output ready);
endinterface

// ===== src/crypt_base64_encoder_unit.sv =====
// channel  dir  payload                          handshake
// req      in   data_byte[7:0], final_byte       valid/ready
// rsp      out  out_char[6:0], final_char        valid/ready
//
// a byte is held in an input register, encoded in one pass and moved into a
// two-character output queue; one character leaves per cycle while rsp is ready
// one byte per cycle while it yields one character and rsp is ready; a group of
// three bytes yields four characters, and bytes that each yield two characters
// wait on the output queue, whose drain rate sets the sustained byte rate
// synchronous active-high reset empties the input register and the output queue and restarts the group
// a stall on rsp fills the queue and then holds the byte in the input register
module crypt_base64_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   b64e_req_if.sink    req,
   b64e_rsp_if.source  rsp
);
   import b64e_pkg::*;

   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff;
   logic       hold_final_ff;
   logic       room;
   logic       fire;
   logic       two_chars;
   push_type   enc;

   // held byte moves on when the queue has space for its characters
   assign fire      = hold_valid_ff && room;
   assign req.ready = !hold_valid_ff || fire;

   assign hold_valid_in = (req.valid && req.ready) || (hold_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         hold_byte_ff  <= req.data_byte;
         hold_final_ff <= req.final_byte;
      end
   end

   b64e_encode u_encode (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (hold_byte_ff),
      .final_byte (hold_final_ff),
      .two_chars  (two_chars),
      .result     (enc)
   );

   b64e_char_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (enc),
      .need_two (two_chars),
      .room     (room),
      .rsp      (rsp)
   );

`ifndef SYNTHESIS
   // a blocked byte stays put
   assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && !fire) |=> (hold_valid_ff && $stable(hold_byte_ff)))
      else $error("held byte lost while blocked");

   // two characters pushed leave the queue non-empty
   assert property (@(posedge clock) disable iff (reset)
      (fire && enc.two) |=> rsp.valid)
      else $error("queue empty after a two-character transaction");

   // last byte always flushes a flagged closing character
   assert property (@(posedge clock) disable iff (reset)
      (fire && hold_final_ff) |-> (enc.two && enc.second.final_char
                                   && !enc.first.final_char))
      else $error("final byte without closing character");
`endif

endmodule

// ===== src/b64e_encode.sv =====
module b64e_encode (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   input  logic                final_byte,
   output logic                two_chars,
   output b64e_pkg::push_type  result
);
   import b64e_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;

   // second character when the group closes or the message ends
   assign two_chars = (phase_ff == PHASE_TWO) || final_byte;

   // characters and next state from the held byte and the carried bits
   always_comb begin
      result                   = '0;
      result.valid             = fire;
      result.two               = two_chars;
      result.first.final_char  = 1'b0;
      result.second.final_char = final_byte;
      phase_in                 = phase_ff;
      carry_in                 = carry_ff;
      unique case (phase_ff)
         PHASE_ONE: begin
            result.first.out_char  = sextet_char({carry_ff[1:0], data_byte[7:4]});
            result.second.out_char = sextet_char({data_byte[3:0], 2'b00});
            phase_in               = final_byte ? PHASE_START : PHASE_TWO;
            carry_in               = final_byte ? 4'd0 : data_byte[3:0];
         end
         PHASE_TWO: begin
            result.first.out_char  = sextet_char({carry_ff, data_byte[7:6]});
            result.second.out_char = sextet_char(data_byte[5:0]);
            phase_in               = PHASE_START;
            carry_in               = 4'd0;
         end
         default: begin
            // start of group, also any stray code
            result.first.out_char  = sextet_char(data_byte[7:2]);
            result.second.out_char = sextet_char({data_byte[1:0], 4'b0000});
            phase_in               = final_byte ? PHASE_START : PHASE_ONE;
            carry_in               = final_byte ? 4'd0 : {2'b00, data_byte[1:0]};
         end
      endcase
   end

   // group state advances once per consumed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_START;
         carry_ff <= 4'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

// ===== src/b64e_char_queue.sv =====
module b64e_char_queue (
   input  logic                clock,
   input  logic                reset,
   input  b64e_pkg::push_type  push,
   input  logic                need_two,
   output logic                room,
   b64e_rsp_if.source          rsp
);
   import b64e_pkg::*;

   localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);

   char_type                slot_ff [QUEUE_DEPTH];
   char_type                slot_in [QUEUE_DEPTH];
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [CountWidth-1:0]   base;
   logic [CountWidth-1:0]   need;
   logic                    pop;

   assign pop          = (count_ff != '0) && rsp.ready;
   assign base         = count_ff - CountWidth'(pop);
   assign need         = need_two ? CountWidth'(2) : CountWidth'(1);
   assign room         = (CountWidth'(QUEUE_DEPTH) - base) >= need;

   assign rsp.valid      = (count_ff != '0);
   assign rsp.out_char   = slot_ff[0].out_char;
   assign rsp.final_char = slot_ff[0].final_char;

   // shift out the head, then write new characters behind what is left
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && (i + 1 < QUEUE_DEPTH)) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (push.valid && (CountWidth'(i) == base)) begin
            slot_in[i] = push.first;
         end
         if (push.valid && push.two && (CountWidth'(i) == base + CountWidth'(1))) begin
            slot_in[i] = push.second;
         end
      end
      count_in = base;
      if (push.valid) begin
         count_in = base + (push.two ? CountWidth'(2) : CountWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule
